@@ rtl/iocnt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iocnt_pkg
// shared types and constants of the interval overlap counter
// ----------------------------------------------------------------------------
package iocnt_pkg;

   localparam int CMD_WIDTH   = 2;
   localparam int TIME_WIDTH  = 32;
   localparam int END_WIDTH   = TIME_WIDTH + 1;
   localparam int COUNT_WIDTH = 11;

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_CLEAR = 2'd0,
      CMD_LOAD  = 2'd1,
      CMD_QUERY = 2'd2
   } cmd_type;

   // command code with no meaning, dropped at the front
   localparam logic [CMD_WIDTH-1:0] CMD_CODE_UNUSED = 2'd3;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   typedef struct packed {
      cmd_type               kind;
      logic [TIME_WIDTH-1:0] time_start;
      logic [END_WIDTH-1:0]  time_end;
   } cmd_item_type;

   typedef struct packed {
      logic [COUNT_WIDTH-1:0] overlap_count;
      logic                   overflow_seen;
   } rsp_item_type;

endpackage
`default_nettype wire

@@ rtl/iocnt_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iocnt_queue
// small first-in first-out queue of fixed-width entries
// ----------------------------------------------------------------------------
module iocnt_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
   localparam logic [NW-1:0] FULL_COUNT = NW'(DEPTH);

   logic [WIDTH-1:0] slots_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]    fill_ff, fill_in;
   logic             do_push, do_pop;

   assign full     = (fill_ff == FULL_COUNT);
   assign empty    = (fill_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

@@ rtl/iocnt_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iocnt_front
// accepts request transfers, drops unused codes, forms the interval end
// and queues commands for the back end
// ----------------------------------------------------------------------------
module iocnt_front #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_push,
   output logic                                     req_full,
   input  wire logic [iocnt_pkg::CMD_WIDTH-1:0]     req_cmd,
   input  wire logic [iocnt_pkg::TIME_WIDTH-1:0]    req_time_start,
   input  wire logic [iocnt_pkg::TIME_WIDTH-1:0]    req_time_length,
   output iocnt_pkg::cmd_item_type                  cmd_item,
   output logic                                     cmd_valid,
   input  wire logic                                cmd_pop
);

   iocnt_pkg::cmd_item_type new_item;
   logic                    queue_push;
   logic                    queue_empty;

   always_comb begin
      new_item.kind       = iocnt_pkg::cmd_type'(req_cmd);
      new_item.time_start = req_time_start;
      new_item.time_end   = {1'b0, req_time_start} + {1'b0, req_time_length};
   end

   assign queue_push = req_push && (req_cmd != iocnt_pkg::CMD_CODE_UNUSED);
   assign cmd_valid  = !queue_empty;

   iocnt_queue #(
      .WIDTH ($bits(iocnt_pkg::cmd_item_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_data (new_item),
      .full      (req_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_item),
      .empty     (queue_empty)
   );

endmodule
`default_nettype wire

@@ rtl/iocnt_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iocnt_back
// interval table and command engine: clear, append and overlap scan
// ----------------------------------------------------------------------------
module iocnt_back #(
   parameter int CAPACITY = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire iocnt_pkg::cmd_item_type  cmd_item,
   input  wire logic                     cmd_valid,
   output logic                          cmd_pop,
   output iocnt_pkg::rsp_item_type       rsp_item,
   output logic                          rsp_push,
   input  wire logic                     rsp_full
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int EW = iocnt_pkg::TIME_WIDTH + iocnt_pkg::END_WIDTH;
   localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

   logic [EW-1:0] entry_mem_ff [CAPACITY];
   logic [EW-1:0] rd_data_ff;
   logic          mem_we, rd_en;

   iocnt_pkg::state_type state_ff, state_in;
   logic [CW-1:0]                       count_ff, count_in;
   logic                                drop_ff, drop_in;
   logic [CW-1:0]                       idx_ff, idx_in;
   logic [CW-1:0]                       hits_ff, hits_in;
   logic                                rd_valid_ff, rd_valid_in;
   logic [iocnt_pkg::TIME_WIDTH-1:0]    qs_ff, qs_in;
   logic [iocnt_pkg::END_WIDTH-1:0]     qe_ff, qe_in;

   logic [iocnt_pkg::TIME_WIDTH-1:0]    rd_start;
   logic [iocnt_pkg::END_WIDTH-1:0]     rd_end;
   logic                                hit;

   assign rd_start = rd_data_ff[EW-1 -: iocnt_pkg::TIME_WIDTH];
   assign rd_end   = rd_data_ff[iocnt_pkg::END_WIDTH-1:0];
   assign hit      = ({1'b0, rd_start} < qe_ff) && (rd_end > {1'b0, qs_ff});

   assign rsp_item.overlap_count = iocnt_pkg::COUNT_WIDTH'(hits_ff);
   assign rsp_item.overflow_seen = drop_ff;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      drop_in     = drop_ff;
      idx_in      = idx_ff;
      hits_in     = hits_ff;
      rd_valid_in = 1'b0;
      qs_in       = qs_ff;
      qe_in       = qe_ff;
      cmd_pop     = 1'b0;
      mem_we      = 1'b0;
      rd_en       = 1'b0;
      rsp_push    = 1'b0;
      case (state_ff)
         iocnt_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               case (cmd_item.kind)
                  iocnt_pkg::CMD_CLEAR: begin
                     cmd_pop  = 1'b1;
                     count_in = '0;
                     drop_in  = 1'b0;
                  end
                  iocnt_pkg::CMD_LOAD: begin
                     cmd_pop = 1'b1;
                     if (count_ff != CAP_COUNT) begin
                        mem_we   = 1'b1;
                        count_in = count_ff + 1'b1;
                     end else begin
                        drop_in = 1'b1;
                     end
                  end
                  iocnt_pkg::CMD_QUERY: begin
                     // a free result slot now stays free until the scan ends
                     if (!rsp_full) begin
                        cmd_pop  = 1'b1;
                        qs_in    = cmd_item.time_start;
                        qe_in    = cmd_item.time_end;
                        idx_in   = '0;
                        hits_in  = '0;
                        state_in = iocnt_pkg::ST_SCAN;
                     end
                  end
                  default: begin
                     cmd_pop = 1'b1;
                  end
               endcase
            end
         end
         iocnt_pkg::ST_SCAN: begin
            if (rd_valid_ff && hit) begin
               hits_in = hits_ff + 1'b1;
            end
            if (idx_ff != count_ff) begin
               rd_en       = 1'b1;
               rd_valid_in = 1'b1;
               idx_in      = idx_ff + 1'b1;
            end else if (!rd_valid_ff) begin
               rsp_push = 1'b1;
               state_in = iocnt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = iocnt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= iocnt_pkg::ST_IDLE;
         count_ff    <= '0;
         drop_ff     <= 1'b0;
         rd_valid_ff <= 1'b0;
         idx_ff      <= '0;
         hits_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         drop_ff     <= drop_in;
         rd_valid_ff <= rd_valid_in;
         idx_ff      <= idx_in;
         hits_ff     <= hits_in;
      end
   end

   always_ff @(posedge clock) begin
      qs_ff <= qs_in;
      qe_ff <= qe_in;
   end

   // interval table, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem_ff[count_ff[AW-1:0]] <= {cmd_item.time_start, cmd_item.time_end};
      end
      if (rd_en) begin
         rd_data_ff <= entry_mem_ff[idx_ff[AW-1:0]];
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_COUNT)
      else $error("entry count beyond capacity");

   a_push_in_scan: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> (state_ff == iocnt_pkg::ST_SCAN) && !rsp_full)
      else $error("result pushed outside a scan or into a full queue");

   a_hits_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == iocnt_pkg::ST_SCAN) |-> (hits_ff <= idx_ff) && (idx_ff <= count_ff))
      else $error("scan counters out of order");

   a_load_append: assert property (@(posedge clock) disable iff (reset)
      mem_we |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("load did not advance the entry count");

endmodule
`default_nettype wire

@@ rtl/interval_overlap_counter_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// interval_overlap_counter_top
// table of time intervals with clear, append and overlap count queries
// ----------------------------------------------------------------------------
// Clear and load commands complete in the back end's idle state. A query reads
// the interval table through its single read port, one stored interval per
// cycle, and its result then enters the two-entry result queue. A four-entry
// command queue sits in front of the back end, so requests are accepted while
// a scan runs and a result waits to be taken.
// Command code 3 is accepted and discarded.
// No clearing pass is needed after reset; the table is empty at once.
module interval_overlap_counter_top #(
   parameter int CAPACITY = 1024
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_push,
   output logic                                     req_full,
   input  wire logic [iocnt_pkg::CMD_WIDTH-1:0]     req_cmd,
   input  wire logic [iocnt_pkg::TIME_WIDTH-1:0]    req_time_start,
   input  wire logic [iocnt_pkg::TIME_WIDTH-1:0]    req_time_length,
   input  wire logic                                rsp_pop,
   output logic                                     rsp_empty,
   output logic [iocnt_pkg::COUNT_WIDTH-1:0]        rsp_overlap_count,
   output logic                                     rsp_overflow_seen
);

   iocnt_pkg::cmd_item_type cmd_item;
   logic                    cmd_valid;
   logic                    cmd_pop;
   iocnt_pkg::rsp_item_type rsp_new;
   iocnt_pkg::rsp_item_type rsp_head;
   logic                    rsp_push;
   logic                    rsp_full;

   iocnt_front #(
      .QUEUE_DEPTH (4)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_cmd         (req_cmd),
      .req_time_start  (req_time_start),
      .req_time_length (req_time_length),
      .cmd_item        (cmd_item),
      .cmd_valid       (cmd_valid),
      .cmd_pop         (cmd_pop)
   );

   iocnt_back #(
      .CAPACITY (CAPACITY)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_item  (cmd_item),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .rsp_item  (rsp_new),
      .rsp_push  (rsp_push),
      .rsp_full  (rsp_full)
   );

   iocnt_queue #(
      .WIDTH ($bits(iocnt_pkg::rsp_item_type)),
      .DEPTH (2)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_new),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_head),
      .empty     (rsp_empty)
   );

   assign rsp_overlap_count = rsp_head.overlap_count;
   assign rsp_overflow_seen = rsp_head.overflow_seen;

endmodule
`default_nettype wire
